FILE: hw/rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 8;
  localparam int unsigned LenW        = 5;
  localparam int unsigned DefCapacity = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_APPEND = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module ple_mem #(
  parameter int unsigned Depth = ple_pkg::DefCapacity
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [$clog2(Depth)-1:0]          waddr_i,
  input  wire logic [ple_pkg::DataW-1:0]         wdata_i,
  input  wire logic                              re_i,
  input  wire logic [$clog2(Depth)-1:0]          raddr_i,
  output logic      [ple_pkg::DataW-1:0]         rdata_o
);

  logic [ple_pkg::DataW-1:0] mem_q [Depth];
  logic [ple_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: command sequencer and result register.
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a single-port
// read / single-port write memory with registered read data. One command
// is worked at a time; in_stall_o is low only while the sequencer is idle, and
// a finished result waits in the output register without blocking the next
// command. Insert at position p on a list of n entries moves the n-p tail
// entries up by one, one entry per cycle through the memory read/write loop,
// then writes the new value. Erase moves the n-p-1 entries behind the gap
// down. Read streams one beat per cycle when the output is not stalled; the
// memory read port sets that pace. Full insert, empty erase, empty read and
// mode 3 give a single beat. Every beat of insert and erase carries
// out_value 0 and last 1; list_length always shows the count after the
// command. The memory needs no clearing: only entries below the count are
// ever read, and all of those have been written.
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::DefCapacity
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic [ple_pkg::PosW-1:0]            position_i,
  input  wire logic signed [ple_pkg::DataW-1:0]    item_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [ple_pkg::DataW-1:0]         out_value_o,
  output logic [1:0]                               status_o,
  output logic [ple_pkg::LenW-1:0]                 list_length_o,
  output logic                                     last_o
);

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned PosW  = ple_pkg::PosW;
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned LenW  = ple_pkg::LenW;
  localparam int unsigned DataW = ple_pkg::DataW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS   = 6'b000010,
    S_PUT   = 6'b000100,
    S_ERA   = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  at_q, at_d;
  logic [IdxW-1:0]  wr_addr_q, wr_addr_d;
  logic             wr_pend_q, wr_pend_d;
  logic [DataW-1:0] val_q, val_d;
  ple_pkg::status_e resp_status_q, resp_status_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  ple_pkg::status_e out_status_q, out_status_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic             out_last_q, out_last_d;

  // Memory port.
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic [DataW-1:0] mem_rdata;

  logic             in_accept;
  logic             slot_free;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  cnt_ext;
  logic [CntW-1:0]  idx_next;
  ple_pkg::mode_e   mode;

  ple_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign mode       = ple_pkg::mode_e'(mode_i);
  assign pos_ext    = CmpW'(position_i);
  assign cnt_ext    = CmpW'(count_q);
  assign idx_next   = CntW'(idx_q) + CntW'(1);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    at_d          = at_q;
    wr_addr_d     = wr_addr_q;
    wr_pend_d     = 1'b0;
    val_d         = val_q;
    resp_status_d = resp_status_q;

    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          resp_status_d = ple_pkg::ST_OK;
          val_d         = item_value_i;
          unique case (mode)
            ple_pkg::MODE_INSERT: begin
              if (count_q >= CntW'(CAPACITY)) begin
                resp_status_d = ple_pkg::ST_FULL;
                state_d       = S_RESP;
              end else begin
                // Clamp to the end; past the end is flagged as an append.
                if (pos_ext > cnt_ext) begin
                  at_d          = IdxW'(count_q);
                  resp_status_d = ple_pkg::ST_APPEND;
                end else begin
                  at_d = IdxW'(position_i);
                end
                idx_d   = IdxW'(count_q);
                state_d = S_INS;
              end
            end
            ple_pkg::MODE_ERASE: begin
              if (count_q == '0) begin
                resp_status_d = ple_pkg::ST_EMPTY;
                state_d       = S_RESP;
              end else begin
                if (pos_ext >= cnt_ext) begin
                  at_d  = IdxW'(count_q - CntW'(1));
                  idx_d = IdxW'(count_q - CntW'(1));
                end else begin
                  at_d  = IdxW'(position_i);
                  idx_d = IdxW'(position_i);
                end
                state_d = S_ERA;
              end
            end
            ple_pkg::MODE_READ: begin
              if (count_q == '0) begin
                resp_status_d = ple_pkg::ST_EMPTY;
                state_d       = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = S_READ;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the tail: write the entry read last cycle one slot up.
        mem_we = wr_pend_q;
        if (idx_q != at_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - IdxW'(1);
          wr_addr_d = idx_q;
          wr_pend_d = 1'b1;
          idx_d     = idx_q - IdxW'(1);
        end else begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = at_q;
        mem_wdata = val_q;
        count_d   = count_q + CntW'(1);
        state_d   = S_RESP;
      end

      S_ERA: begin
        // Walk up from the gap: write the entry read last cycle one slot down.
        mem_we = wr_pend_q;
        if (idx_next < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = IdxW'(idx_next);
          wr_addr_d = idx_q;
          wr_pend_d = 1'b1;
          idx_d     = IdxW'(idx_next);
        end else begin
          count_d = count_q - CntW'(1);
          state_d = S_RESP;
        end
      end

      S_READ: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = mem_rdata;
          out_status_d = ple_pkg::ST_OK;
          out_len_d    = LenW'(count_q);
          out_last_d   = (idx_next == count_q);
          if (idx_next == count_q) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IdxW'(idx_next);
            idx_d     = IdxW'(idx_next);
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = resp_status_q;
          out_len_d    = LenW'(count_q);
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    at_q          <= at_d;
    wr_addr_q     <= wr_addr_d;
    val_q         <= val_d;
    resp_status_q <= resp_status_d;
    out_value_q   <= out_value_d;
    out_status_q  <= out_status_d;
    out_len_q     <= out_len_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign status_o      = out_status_q;
  assign list_length_o = out_len_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_same_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write of the same entry in one cycle");

  a_full_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ple_pkg::ST_FULL |-> list_length_o == LenW'(CAPACITY))
    else $error("full status with short list");

  a_empty_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ple_pkg::ST_EMPTY |-> list_length_o == '0 && last_o)
    else $error("empty status with nonzero length");
`endif

endmodule

`default_nettype wire

FILE: dv/ple_list_checker.sv
// Scoreboard of the positional list engine: shadow list, expected beats and compare.
module ple_list_checker #(
  parameter int unsigned CAPACITY = ple_pkg::DefCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [1:0]                       mode_i,
  input  logic [ple_pkg::PosW-1:0]         position_i,
  input  logic signed [ple_pkg::DataW-1:0] item_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [ple_pkg::DataW-1:0] out_value_i,
  input  logic [1:0]                       status_i,
  input  logic [ple_pkg::LenW-1:0]         list_length_i,
  input  logic                             last_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  typedef struct {
    logic signed [ple_pkg::DataW-1:0] value;
    ple_pkg::status_e                 status;
    logic [ple_pkg::LenW-1:0]         length;
    logic                             last;
  } beat_t;

  logic signed [ple_pkg::DataW-1:0] shadow_list[$];
  beat_t                            expected_beats[$];
  int                               mismatch_count = 0;
  int                               beat_index = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] out beat %0d: %s", $time, beat_index, what);
  endtask

  // Length always shows the list size after the command has been applied.
  function automatic void push_beat(input logic signed [ple_pkg::DataW-1:0] value,
                                    input ple_pkg::status_e status, input logic last);
    beat_t b;
    b.value  = value;
    b.status = status;
    b.length = ple_pkg::LenW'(shadow_list.size());
    b.last   = last;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic void model_command(input ple_pkg::mode_e mode,
                                        input logic [ple_pkg::PosW-1:0] pos,
                                        input logic signed [ple_pkg::DataW-1:0] value);
    int unsigned fill;
    int unsigned at;
    fill = shadow_list.size();
    at   = pos;
    case (mode)
      ple_pkg::MODE_INSERT: begin
        if (fill >= CAPACITY) begin
          push_beat('0, ple_pkg::ST_FULL, 1'b1);
        end else if (at > fill) begin
          shadow_list.insert(fill, value);
          push_beat('0, ple_pkg::ST_APPEND, 1'b1);
        end else begin
          shadow_list.insert(at, value);
          push_beat('0, ple_pkg::ST_OK, 1'b1);
        end
      end
      ple_pkg::MODE_ERASE: begin
        if (fill == 0) begin
          push_beat('0, ple_pkg::ST_EMPTY, 1'b1);
        end else begin
          if (at > fill - 1) at = fill - 1;
          shadow_list.delete(at);
          push_beat('0, ple_pkg::ST_OK, 1'b1);
        end
      end
      ple_pkg::MODE_READ: begin
        if (fill == 0) begin
          push_beat('0, ple_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) begin
            push_beat(shadow_list[i], ple_pkg::ST_OK, i == fill - 1);
          end
        end
      end
      default: begin
        push_beat('0, ple_pkg::ST_OK, 1'b1);
      end
    endcase
  endfunction

  task automatic check_beat();
    beat_t want;
    beat_index++;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat value %0d status %0d length %0d last %0b",
                                out_value_i, status_i, list_length_i, last_i));
      return;
    end
    want = expected_beats.pop_front();
    if (out_value_i !== want.value) begin
      report_mismatch($sformatf("out_value got %0d expected %0d", out_value_i, want.value));
    end
    if (status_i !== want.status) begin
      report_mismatch($sformatf("status got %0d expected %0d", status_i, want.status));
    end
    if (list_length_i !== want.length) begin
      report_mismatch($sformatf("list_length got %0d expected %0d",
                                list_length_i, want.length));
    end
    if (last_i !== want.last) begin
      report_mismatch($sformatf("last got %0b expected %0b", last_i, want.last));
    end
  endtask

  // Retire the output beat first: a command taken at this edge cannot have a result yet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      expected_beats.delete();
      pending_o    <= 0;
      fail_count_o <= mismatch_count;
    end else begin
      if (out_valid_i && !out_stall_i) check_beat();
      if (in_valid_i && !in_stall_i) begin
        model_command(ple_pkg::mode_e'(mode_i), position_i, item_value_i);
      end
      pending_o    <= expected_beats.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

FILE: dv/tb_positional_list_engine.sv
// Testbench top of the positional list engine: clock, reset, command stimulus and verdict.
module tb_positional_list_engine;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 3;
  // Watchdog limit, set well above the slowest legal run.
  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 460;
  // Alternate fill-up and drain-down segments so full and empty lists come often.
  localparam int SegmentLen  = 48;
  // Wait well past the longest command at the end.
  localparam int DrainCycles = 60;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  ple_pkg::mode_e                   mode_drv = ple_pkg::MODE_INSERT;
  logic [ple_pkg::PosW-1:0]         position = '0;
  logic signed [ple_pkg::DataW-1:0] item_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [ple_pkg::DataW-1:0] out_value;
  logic [1:0]                       status;
  logic [ple_pkg::LenW-1:0]         list_length;
  logic                             last;

  int send_idle_pct = 9;
  int recv_idle_pct = 62;
  int cycle_count = 0;
  int fail_count;
  int pending_count;

  always #ClkHalf clk = ~clk;

  positional_list_engine dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode_drv),
    .position_i    (position),
    .item_value_i  (item_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_value_o   (out_value),
    .status_o      (status),
    .list_length_o (list_length),
    .last_o        (last)
  );

  ple_list_checker list_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .mode_i        (mode_drv),
    .position_i    (position),
    .item_value_i  (item_value),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_value_i   (out_value),
    .status_i      (status),
    .list_length_i (list_length),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // Receiver back-pressure: redraw the stall every falling edge at the current rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL positional_list_engine");
      $finish;
    end
  end

  // Present one command beat and hold it until the block takes it. Enter and leave on a
  // falling edge, so valid stays high across back-to-back beats without a glitch.
  task automatic send_command(input ple_pkg::mode_e mode,
                              input logic [ple_pkg::PosW-1:0] pos,
                              input logic signed [ple_pkg::DataW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode_drv   <= mode;
    position   <= pos;
    item_value <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly the interesting range around the list length, sometimes any byte.
  function automatic logic [ple_pkg::PosW-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return ple_pkg::PosW'($urandom_range(17));
    if (r < 90) return ple_pkg::PosW'($urandom_range(255));
    return '1;
  endfunction

  function automatic logic signed [ple_pkg::DataW-1:0] pick_value();
    case ($urandom_range(39))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Bias toward insert while filling and toward erase while draining; read stays frequent.
  function automatic ple_pkg::mode_e pick_mode(input logic filling);
    int unsigned r;
    r = $urandom_range(99);
    if (r >= 95) return ple_pkg::MODE_NOP;
    if (r >= 75) return ple_pkg::MODE_READ;
    if (filling) return (r < 60) ? ple_pkg::MODE_INSERT : ple_pkg::MODE_ERASE;
    return (r < 20) ? ple_pkg::MODE_INSERT : ple_pkg::MODE_ERASE;
  endfunction

  initial begin
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: read, erase past the end, and the unused mode.
    send_command(ple_pkg::MODE_READ,   8'd0,   32'sd0);
    send_command(ple_pkg::MODE_ERASE,  8'd255, 32'sd0);
    send_command(ple_pkg::MODE_NOP,    8'd255, 32'sh7fff_ffff);

    // Insert at the length, past the length, at the front and in the middle.
    send_command(ple_pkg::MODE_INSERT, 8'd0,   32'sh8000_0000);
    send_command(ple_pkg::MODE_INSERT, 8'd255, 32'sh7fff_ffff);
    send_command(ple_pkg::MODE_INSERT, 8'd2,   -32'sd1);
    send_command(ple_pkg::MODE_INSERT, 8'd0,   32'sd0);
    send_command(ple_pkg::MODE_INSERT, 8'd2,   32'sh5a5a_5a5a);
    send_command(ple_pkg::MODE_INSERT, 8'd9,   32'sd1);
    send_command(ple_pkg::MODE_READ,   8'd0,   32'sd0);

    // Fill to capacity, then insert into the full list and read it all out.
    for (int i = 0; i < 10; i++) begin
      send_command(ple_pkg::MODE_INSERT, ple_pkg::PosW'((i * 5) % 19), $urandom);
    end
    send_command(ple_pkg::MODE_INSERT, 8'd3,   32'sh1234_5678);
    send_command(ple_pkg::MODE_READ,   8'd0,   32'sd0);

    // Erase at the front, at the length, and far past the end.
    send_command(ple_pkg::MODE_ERASE,  8'd0,   32'sd0);
    send_command(ple_pkg::MODE_ERASE,  8'd15,  32'sd0);
    send_command(ple_pkg::MODE_ERASE,  8'd255, 32'sd0);
    send_command(ple_pkg::MODE_READ,   8'd0,   32'sd0);

    // Random traffic; swap the idle rates after a third, then drop idling entirely.
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 9;
      end else if (n == 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_command(pick_mode(((n / SegmentLen) % 2) == 0), pick_position(), pick_value());
    end
    in_valid <= 1'b0;

    // Drain every expected beat, then watch a while for stray output.
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS positional_list_engine");
    end else begin
      $display("FAIL positional_list_engine");
    end
    $finish;
  end

endmodule
